>>> hdl/pit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and constants of the point-in-tetrahedron test.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int TOL_BITS  = 24;  // tolerance register width
  localparam int FRAC_BITS = 24;  // fraction bits of a volume (three Q.8 factors)
  localparam int CFG_IDX_W = 2;
  localparam int VOL_LAT   = 6;   // stages of the volume unit
  localparam int CHK_LAT   = 4;   // stages of the bound check

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOC_X,
    CFG_LOC_Y,
    CFG_LOC_Z,
    CFG_TOL
  } cfg_idx_t;

  typedef struct packed {
    logic hit;
    logic degen;
  } res_t;

endpackage

>>> hdl/pit_vol6.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_vol6
// Six-fold signed volume (b-a) . ((c-a) x (d-a)), six register stages.
// ----------------------------------------------------------------------------
module pit_vol6 #(
  parameter int C = 24
) (
  input  logic                  clk,
  input  logic signed [C-1:0]   a [3],
  input  logic signed [C-1:0]   b [3],
  input  logic signed [C-1:0]   c [3],
  input  logic signed [C-1:0]   d [3],
  output logic signed [3*C+5:0] vol
);

  localparam int DW  = C + 1;
  localparam int XW  = 2 * DW;
  localparam int CW  = XW + 1;
  localparam int LO  = (CW + 1) / 2;
  localparam int HI  = CW - LO;
  localparam int PLW = DW + LO + 1;
  localparam int PHW = DW + HI;
  localparam int VW  = 3 * C + 6;

  logic signed [DW-1:0]  u1_r [3];
  logic signed [DW-1:0]  p1_r [3];
  logic signed [DW-1:0]  q1_r [3];
  logic signed [DW-1:0]  u2_r [3];
  logic signed [XW-1:0]  xp_r [6];
  logic signed [DW-1:0]  u3_r [3];
  logic signed [CW-1:0]  cr_r [3];
  logic signed [PLW-1:0] pl_r [3];
  logic signed [PHW-1:0] ph_r [3];
  logic signed [VW-1:0]  tm_r [3];
  logic signed [VW-1:0]  vol_r;

  // stage 1: edge vectors
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      u1_r[k] <= DW'(b[k]) - DW'(a[k]);
      p1_r[k] <= DW'(c[k]) - DW'(a[k]);
      q1_r[k] <= DW'(d[k]) - DW'(a[k]);
    end
  end

  // stage 2: cross product terms
  always_ff @(posedge clk) begin
    xp_r[0] <= p1_r[1] * q1_r[2];
    xp_r[1] <= p1_r[2] * q1_r[1];
    xp_r[2] <= p1_r[2] * q1_r[0];
    xp_r[3] <= p1_r[0] * q1_r[2];
    xp_r[4] <= p1_r[0] * q1_r[1];
    xp_r[5] <= p1_r[1] * q1_r[0];
    u2_r    <= u1_r;
  end

  // stage 3: cross product components
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      cr_r[k] <= CW'(xp_r[2*k]) - CW'(xp_r[2*k+1]);
    end
    u3_r <= u2_r;
  end

  // stage 4: dot product, split into low and high partial products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pl_r[k] <= u3_r[k] * $signed({1'b0, cr_r[k][LO-1:0]});
      ph_r[k] <= u3_r[k] * $signed(cr_r[k][CW-1:LO]);
    end
  end

  // stage 5: recombine each term
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      tm_r[k] <= (VW'(ph_r[k]) <<< LO) + VW'(pl_r[k]);
    end
  end

  // stage 6: sum of terms
  always_ff @(posedge clk) begin
    vol_r <= tm_r[0] + tm_r[1] + tm_r[2];
  end

  assign vol = vol_r;

endmodule

>>> hdl/pit_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_check
// Degeneracy test and barycentric bound check by cross multiplication.
// ----------------------------------------------------------------------------
module pit_check #(
  parameter int C = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [pit_pkg::TOL_BITS-1:0]  tol,
  input  logic signed [3*C+5:0]         tot,
  input  logic signed [3*C+5:0]         sv [4],
  output logic                          vld_o,
  output pit_pkg::res_t                 res_o
);

  import pit_pkg::*;

  localparam int VW  = 3 * C + 6;
  localparam int DVW = VW + 1;
  localparam int AW  = (VW + 2) / 3;
  localparam int PW  = TOL_BITS + AW;
  localparam int TW  = TOL_BITS + 3 * AW;
  localparam int EW  = TW + FRAC_BITS + 2;

  logic [CHK_LAT-1:0]   vld_r;

  logic signed [VW-1:0] absv1_r;
  logic signed [VW-1:0] svn1_r [4];
  logic                 degen1_r;

  logic [3*AW-1:0]      absp;
  logic [PW-1:0]        pp_r [3];
  logic signed [VW-1:0] absv2_r;
  logic signed [VW-1:0] svn2_r [4];
  logic                 degen2_r;

  logic [TW-1:0]        t_r;
  logic signed [VW-1:0] sv3_r [4];
  logic signed [DVW-1:0] d3_r [4];
  logic                 degen3_r;

  logic [3:0]           ok;
  res_t                 res_nxt;
  res_t                 res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CHK_LAT-2:0], vld_i};
    end
  end

  // stage 1: orientation and degeneracy
  always_ff @(posedge clk) begin
    absv1_r  <= tot[VW-1] ? -tot : tot;
    degen1_r <= $unsigned(tot[VW-1] ? -tot : tot) <= {{(VW-TOL_BITS){1'b0}}, tol};
    for (int i = 0; i < 4; i++) begin
      svn1_r[i] <= tot[VW-1] ? -sv[i] : sv[i];
    end
  end

  // stage 2: tol * |V| partial products
  assign absp = (3*AW)'($unsigned(absv1_r));

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pp_r[j] <= tol * absp[j*AW +: AW];
    end
    absv2_r  <= absv1_r;
    svn2_r   <= svn1_r;
    degen2_r <= degen1_r;
  end

  // stage 3: tol * |V| and distance to the upper bound
  always_ff @(posedge clk) begin
    t_r <= TW'(pp_r[0]) + (TW'(pp_r[1]) << AW) + (TW'(pp_r[2]) << (2*AW));
    for (int i = 0; i < 4; i++) begin
      d3_r[i]  <= DVW'(svn2_r[i]) - DVW'(absv2_r);
      sv3_r[i] <= svn2_r[i];
    end
    degen3_r <= degen2_r;
  end

  // stage 4: -tol*|V| <= Vi*2^F <= (2^F+tol)*|V|
  always_comb begin
    logic signed [EW-1:0] tv;
    logic signed [EW-1:0] svs;
    logic signed [EW-1:0] dsh;
    tv = $signed(EW'(t_r));
    for (int i = 0; i < 4; i++) begin
      svs   = EW'(sv3_r[i]) <<< FRAC_BITS;
      dsh   = EW'(d3_r[i]) <<< FRAC_BITS;
      ok[i] = (svs + tv >= 0) && (dsh <= tv);
    end
    res_nxt.degen = degen3_r;
    res_nxt.hit   = !degen3_r && (&ok);
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign vld_o = vld_r[CHK_LAT-1];
  assign res_o = res_r;

endmodule

>>> hdl/point_in_tetrahedron_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test
// Barycentric point-in-tetrahedron test in exact fixed point.
//
// Usage: write the query point (cfg index 0..2) and the tolerance (index 3)
// through the cfg port while no word is in flight. A word, the four vertices
// of one tetrahedron, is taken on every edge with start high; busy is always
// low, so a new word may follow every cycle.
// Each word yields one result word, shown for one cycle with out_valid
// high, once it has passed 6 stages for the five volume units running
// side by side (multiplier stages of the triple product) and 4 for the
// orientation, tol*|V| product and bound compare. Throughput is one
// word per cycle. Results leave in input order.
// Reset clears the valid line and sets the point to 0 and tol to 1.
// The receiver cannot hold off results; none is ever dropped.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_test #(
  parameter int COORD_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pit_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [((COORD_BITS > pit_pkg::TOL_BITS) ? COORD_BITS : pit_pkg::TOL_BITS)-1:0]
                                          cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_BITS-1:0]    in_v0_x,
  input  logic signed [COORD_BITS-1:0]    in_v0_y,
  input  logic signed [COORD_BITS-1:0]    in_v0_z,
  input  logic signed [COORD_BITS-1:0]    in_v1_x,
  input  logic signed [COORD_BITS-1:0]    in_v1_y,
  input  logic signed [COORD_BITS-1:0]    in_v1_z,
  input  logic signed [COORD_BITS-1:0]    in_v2_x,
  input  logic signed [COORD_BITS-1:0]    in_v2_y,
  input  logic signed [COORD_BITS-1:0]    in_v2_z,
  input  logic signed [COORD_BITS-1:0]    in_v3_x,
  input  logic signed [COORD_BITS-1:0]    in_v3_y,
  input  logic signed [COORD_BITS-1:0]    in_v3_z,
  output logic                            out_valid,
  output logic                            out_inside_res,
  output logic                            out_degenerate
);

  import pit_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int VW  = 3 * C + 6;
  localparam int LAT = VOL_LAT + CHK_LAT;

  logic signed [C-1:0]        loc_x_r;
  logic signed [C-1:0]        loc_y_r;
  logic signed [C-1:0]        loc_z_r;
  logic [TOL_BITS-1:0]        tol_r;

  logic [VOL_LAT-1:0]         vld_r;
  logic                       acc;

  logic signed [C-1:0]        vtx [4][3];
  logic signed [C-1:0]        pt  [3];
  logic signed [VW-1:0]       tot;
  logic signed [VW-1:0]       sv  [4];

  logic                       chk_vld;
  res_t                       chk_res;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_x_r <= '0;
      loc_y_r <= '0;
      loc_z_r <= '0;
      tol_r   <= TOL_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LOC_X: loc_x_r <= cfg_data[C-1:0];
        CFG_LOC_Y: loc_y_r <= cfg_data[C-1:0];
        CFG_LOC_Z: loc_z_r <= cfg_data[C-1:0];
        CFG_TOL:   tol_r   <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VOL_LAT-2:0], acc};
    end
  end

  assign vtx[0] = '{in_v0_x, in_v0_y, in_v0_z};
  assign vtx[1] = '{in_v1_x, in_v1_y, in_v1_z};
  assign vtx[2] = '{in_v2_x, in_v2_y, in_v2_z};
  assign vtx[3] = '{in_v3_x, in_v3_y, in_v3_z};
  assign pt     = '{loc_x_r, loc_y_r, loc_z_r};

  pit_vol6 #(.C(C)) u_vol_tot (
    .clk (clk),
    .a   (vtx[0]),
    .b   (vtx[1]),
    .c   (vtx[2]),
    .d   (vtx[3]),
    .vol (tot)
  );

  pit_vol6 #(.C(C)) u_vol_0 (
    .clk (clk),
    .a   (pt),
    .b   (vtx[1]),
    .c   (vtx[2]),
    .d   (vtx[3]),
    .vol (sv[0])
  );

  pit_vol6 #(.C(C)) u_vol_1 (
    .clk (clk),
    .a   (vtx[0]),
    .b   (pt),
    .c   (vtx[2]),
    .d   (vtx[3]),
    .vol (sv[1])
  );

  pit_vol6 #(.C(C)) u_vol_2 (
    .clk (clk),
    .a   (vtx[0]),
    .b   (vtx[1]),
    .c   (pt),
    .d   (vtx[3]),
    .vol (sv[2])
  );

  pit_vol6 #(.C(C)) u_vol_3 (
    .clk (clk),
    .a   (vtx[0]),
    .b   (vtx[1]),
    .c   (vtx[2]),
    .d   (pt),
    .vol (sv[3])
  );

  pit_check #(.C(C)) u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vld_r[VOL_LAT-1]),
    .tol   (tol_r),
    .tot   (tot),
    .sv    (sv),
    .vld_o (chk_vld),
    .res_o (chk_res)
  );

  assign out_valid      = chk_vld;
  assign out_inside_res = chk_res.hit;
  assign out_degenerate = chk_res.degen;

  a_degen_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inside_res && out_degenerate))
    else $error("degenerate word reported inside");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, LAT))
    else $error("result without accepted word");

endmodule
